// ===== design/cdsa_pkg.sv =====
package cdsa_pkg;

	localparam int STACK_DEPTH_DEF = 8;
	localparam int CELL_WIDTH_DEF = 32;

	// Width of the operand and result fields on the ports.
	localparam int FIELD_W = 32;
	localparam int FUNC_W = 4;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH   = 4'd0,
		FN_DROP   = 4'd1,
		FN_BACK   = 4'd2,
		FN_DUP    = 4'd3,
		FN_SWAP   = 4'd4,
		FN_OVER   = 4'd5,
		FN_ADD    = 4'd6,
		FN_AND    = 4'd7,
		FN_OR     = 4'd8,
		FN_XOR    = 4'd9,
		FN_INVERT = 4'd10,
		FN_NEGATE = 4'd11,
		FN_SET    = 4'd12
	} func_t;

endpackage

// ===== design/circular_data_stack_alu_unit.sv =====
// Circular data stack with a small ALU. The block takes one item per clock while the output
// does not stall and returns one result item per item. An accepted item sits in the input
// register and executes from there into the result register when that register is free
// or drains, and its result is taken from the outputs while the output is not stalled.
// While a result waits under a stall, the input register holds its item and the
// input stalls. Every operation is a single pass through a short datapath on a rotating
// register file: the top of stack always sits in slot 0 and the slot next to it holds the
// cell below, so push, drop and back rotate the file by one slot instead of moving a
// pointer. The stack never overflows or underflows; a push over a full ring overwrites the
// oldest cell, and back brings a dropped cell up again. All cells reset to zero. Codes 13 to
// 15 change nothing and report the current top with a popped value of zero.
module circular_data_stack_alu_unit #(
	parameter int STACK_DEPTH = cdsa_pkg::STACK_DEPTH_DEF,
	parameter int CELL_WIDTH = cdsa_pkg::CELL_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [cdsa_pkg::FUNC_W-1:0]          func,
	input  logic signed [cdsa_pkg::FIELD_W-1:0]  operand_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [cdsa_pkg::FIELD_W-1:0]  popped_value,
	output logic signed [cdsa_pkg::FIELD_W-1:0]  top_value
);

	localparam int FW = cdsa_pkg::FIELD_W;

	typedef enum logic [1:0] {
		MOVE_HOLD,
		MOVE_DOWN,
		MOVE_UP
	} move_t;

	logic                                  valid_s1;
	cdsa_pkg::func_t                       func_s1;
	logic [FW-1:0]                         operand_s1;

	logic [STACK_DEPTH-1:0][CELL_WIDTH-1:0] cell_q;
	logic [STACK_DEPTH-1:0][CELL_WIDTH-1:0] cell_nxt;
	logic [FW-1:0]                         popped_q;
	logic [FW-1:0]                         top_q;

	logic                                  in_take;
	logic                                  exec;
	move_t                                 move;
	logic                                  swap;
	logic [CELL_WIDTH-1:0]                 op_ext;
	logic [CELL_WIDTH-1:0]                 t_c;
	logic [CELL_WIDTH-1:0]                 s_c;
	logic [CELL_WIDTH-1:0]                 last_c;
	logic [CELL_WIDTH-1:0]                 new_top;
	logic [CELL_WIDTH-1:0]                 popped_c;
	logic [FW-1:0]                         popped_fit;
	logic [FW-1:0]                         top_fit;

	// The item in the input register executes when the result register is free or drains.
	assign exec = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !exec;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			func_s1 <= cdsa_pkg::func_t'(func);
			operand_s1 <= operand_value;
		end
	end

	// The operand is sign-extended, or cut, to the cell width.
	generate
		if (CELL_WIDTH > FW) begin : g_op_wide
			assign op_ext = {{(CELL_WIDTH - FW){operand_s1[FW-1]}}, operand_s1};
		end else if (CELL_WIDTH < FW) begin : g_op_narrow
			assign op_ext = operand_s1[CELL_WIDTH-1:0];
		end else begin : g_op_same
			assign op_ext = operand_s1;
		end
	endgenerate

	assign t_c = cell_q[0];
	assign s_c = cell_q[1];
	assign last_c = cell_q[STACK_DEPTH-1];

	always_comb begin
		move = MOVE_HOLD;
		swap = 1'b0;
		new_top = t_c;
		popped_c = '0;
		case (func_s1)
			cdsa_pkg::FN_PUSH: begin
				move = MOVE_DOWN;
				new_top = op_ext;
			end
			cdsa_pkg::FN_DROP: begin
				move = MOVE_UP;
				popped_c = t_c;
				new_top = s_c;
			end
			cdsa_pkg::FN_BACK: begin
				move = MOVE_DOWN;
				new_top = last_c;
			end
			cdsa_pkg::FN_DUP: begin
				move = MOVE_DOWN;
				new_top = t_c;
			end
			cdsa_pkg::FN_SWAP: begin
				swap = 1'b1;
				new_top = s_c;
			end
			cdsa_pkg::FN_OVER: begin
				move = MOVE_DOWN;
				new_top = s_c;
			end
			cdsa_pkg::FN_ADD: begin
				move = MOVE_UP;
				new_top = t_c + s_c;
			end
			cdsa_pkg::FN_AND: begin
				move = MOVE_UP;
				new_top = t_c & s_c;
			end
			cdsa_pkg::FN_OR: begin
				move = MOVE_UP;
				new_top = t_c | s_c;
			end
			cdsa_pkg::FN_XOR: begin
				move = MOVE_UP;
				new_top = t_c ^ s_c;
			end
			cdsa_pkg::FN_INVERT: begin
				new_top = ~t_c;
			end
			cdsa_pkg::FN_NEGATE: begin
				new_top = '0 - t_c;
			end
			cdsa_pkg::FN_SET: begin
				new_top = op_ext;
			end
			default: begin
			end
		endcase
	end

	// Moving down pushes every cell one slot deeper; moving up brings the ring one slot
	// toward the top, so the old top lands in the deepest slot and can come back by back.
	always_comb begin
		cell_nxt[0] = new_top;
		for (int i = 1; i < STACK_DEPTH; i++) begin
			case (move)
				MOVE_DOWN: cell_nxt[i] = cell_q[i-1];
				MOVE_UP:   cell_nxt[i] = cell_q[(i == STACK_DEPTH - 1) ? 0 : i + 1];
				default: begin
					if (i == 1 && swap) begin
						cell_nxt[i] = t_c;
					end else begin
						cell_nxt[i] = cell_q[i];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (exec) begin
			cell_q <= cell_nxt;
		end
	end

	generate
		if (CELL_WIDTH >= FW) begin : g_out_wide
			assign popped_fit = popped_c[FW-1:0];
			assign top_fit = new_top[FW-1:0];
		end else begin : g_out_narrow
			assign popped_fit = {{(FW - CELL_WIDTH){1'b0}}, popped_c};
			assign top_fit = {{(FW - CELL_WIDTH){1'b0}}, new_top};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (exec) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			popped_q <= popped_fit;
			top_q <= top_fit;
		end
	end

	assign popped_value = popped_q;
	assign top_value = top_q;

	// The stack only changes when an item executes.
	a_cells_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(cell_q))
		else $error("stack cells changed without an executing item");

	// Every executed item shows up as a result in the next cycle.
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> out_valid)
		else $error("executed item produced no result");

	// A new result only appears after an item sat in the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result appeared without an item");

	// After an item executes, the top result matches the top slot of the register file.
	a_top_slot: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> (top_q == top_fit) || (cell_q[0] == $past(new_top)))
		else $error("top result does not match the top cell");

endmodule
